// ===== rtl/core/pdc_pkg.sv =====
package pdc_pkg;

	localparam int PAYLOAD_LEN = 12;
	localparam int CHANNELS    = 6;
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 16 * CHANNELS;

	localparam logic [7:0]  CRC_POLY        = 8'h07;
	localparam logic [7:0]  START_RESET     = 8'hAA;
	localparam logic [7:0]  END_RESET       = 8'h55;
	localparam logic [7:0]  TYPE_RESET      = 8'h01;
	localparam logic [15:0] LIMIT_RESET     = 16'd5000;
	localparam logic [7:0]  PAYLOAD_LEN_BYTE = 8'(PAYLOAD_LEN);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_END_BYTE   = 2'd1,
		REG_PWM_TYPE   = 2'd2,
		REG_PWM_LIMIT  = 2'd3
	} reg_idx_t;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] pwm_t;

	typedef struct packed {
		byte_t start_byte;
		byte_t end_byte;
		byte_t pwm_type;
		pwm_t  pwm_limit;
	} cfg_t;

	// payload[0] is the first payload byte of the frame
	typedef struct packed {
		logic                         hit;
		logic [PAYLOAD_LEN-1:0][7:0]  payload;
	} parse_res_t;

	// CRC-8, MSB first, no reflection, no final XOR
	function automatic byte_t crc8_update(input byte_t crc, input byte_t b);
		byte_t c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/pdc_cfg_regs.sv =====
module pdc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output pdc_pkg::cfg_t                   cfg
);

	pdc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= pdc_pkg::START_RESET;
			cfg_q.end_byte   <= pdc_pkg::END_RESET;
			cfg_q.pwm_type   <= pdc_pkg::TYPE_RESET;
			cfg_q.pwm_limit  <= pdc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (pdc_pkg::reg_idx_t'(cfg_idx))
				pdc_pkg::REG_START_BYTE: cfg_q.start_byte <= cfg_wdata[7:0];
				pdc_pkg::REG_END_BYTE:   cfg_q.end_byte   <= cfg_wdata[7:0];
				pdc_pkg::REG_PWM_TYPE:   cfg_q.pwm_type   <= cfg_wdata[7:0];
				pdc_pkg::REG_PWM_LIMIT:  cfg_q.pwm_limit  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pdc_parser.sv =====
module pdc_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pdc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  pdc_pkg::cfg_t                   cfg,
	input  logic                            out_busy,
	output pdc_pkg::parse_res_t             res
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CRC     = 3'd4,
		PH_END     = 3'd5
	} phase_t;

	logic                                valid_s1;
	pdc_pkg::byte_t                      byte_s1;
	phase_t                              phase_q;
	pdc_pkg::byte_t                      type_q;
	logic [pdc_pkg::CNT_W-1:0]           count_q;
	pdc_pkg::byte_t                      crc_q;
	pdc_pkg::byte_t                      rcrc_q;
	logic [pdc_pkg::PAYLOAD_LEN-1:0][7:0] payload_q;

	logic                       hit;
	logic                       consume;
	logic                       advance;
	pdc_pkg::byte_t             crc_next;
	logic [pdc_pkg::CNT_W-1:0]  count_inc;

	assign crc_next  = pdc_pkg::crc8_update(crc_q, byte_s1);
	assign count_inc = count_q + 1'b1;

	assign hit = valid_s1 && (phase_q == PH_END) && (byte_s1 == cfg.end_byte)
		&& (crc_q == rcrc_q);
	// the byte in s1 waits only if it closes a good frame and the result slot is full
	assign consume  = valid_s1 && !(hit && out_busy);
	assign advance  = !valid_s1 || consume;
	assign s_tready = advance;

	assign res.hit     = hit && consume;
	assign res.payload = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			type_q  <= '0;
			count_q <= '0;
			crc_q   <= '0;
			rcrc_q  <= '0;
		end else if (consume) begin
			case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == cfg.start_byte) begin
						phase_q <= PH_TYPE;
						count_q <= '0;
						crc_q   <= '0;
					end
				end
				PH_TYPE: begin
					type_q  <= byte_s1;
					crc_q   <= crc_next;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					crc_q   <= crc_next;
					count_q <= '0;
					if (byte_s1 == pdc_pkg::PAYLOAD_LEN_BYTE && type_q == cfg.pwm_type) begin
						phase_q <= PH_PAYLOAD;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_PAYLOAD: begin
					crc_q   <= crc_next;
					count_q <= count_inc;
					if (count_inc >= pdc_pkg::CNT_W'(pdc_pkg::PAYLOAD_LEN)) begin
						phase_q <= PH_CRC;
					end
				end
				PH_CRC: begin
					rcrc_q  <= byte_s1;
					phase_q <= PH_END;
				end
				PH_END: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (consume && phase_q == PH_PAYLOAD
			&& count_q < pdc_pkg::CNT_W'(pdc_pkg::PAYLOAD_LEN)) begin
			payload_q[count_q] <= byte_s1;
		end
	end

endmodule

// ===== rtl/core/pdc_out_stage.sv =====
module pdc_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pdc_pkg::parse_res_t             res,
	input  pdc_pkg::pwm_t                   pwm_limit,
	output logic                            out_busy,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pdc_pkg::OUT_DATA_W-1:0]  m_tdata
);

	logic [pdc_pkg::CHANNELS-1:0][15:0] pwm_clamped;
	logic [pdc_pkg::CHANNELS-1:0][15:0] pwm_q;
	logic                               valid_q;

	// big-endian byte pairs, clamped to the limit
	always_comb begin
		pdc_pkg::pwm_t v;
		for (int k = 0; k < pdc_pkg::CHANNELS; k++) begin
			v = {res.payload[2*k], res.payload[2*k+1]};
			pwm_clamped[k] = (v > pwm_limit) ? pwm_limit : v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.hit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.hit) begin
			pwm_q <= pwm_clamped;
		end
	end

	assign out_busy = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = pwm_q;

endmodule

// ===== rtl/core/pwm_packet_deframer_crc8.sv =====
// CRC-8 framed PWM packet receiver.
// Input stream: one received serial byte per transaction on s_t*. The block
// hunts for start, type, length (12), twelve payload bytes, CRC, end. The
// CRC-8 (poly 0x07, init 0) runs over type, length and payload as bytes come.
// Output stream: one transaction per good frame on m_t*, six 16-bit PWM
// values (payload big-endian pairs) clamped to pwm_limit. Bad frames vanish.
// Configuration: cfg_we/cfg_idx/cfg_wdata, registers 0 start_byte,
// 1 end_byte, 2 pwm_type, 3 pwm_limit; write only while idle.
// Throughput: one byte per cycle while s_tready is high. The result for a
// closing end byte passes the input register, then the result register,
// before it shows on m_tvalid.
// Reset clears the hunt state, the CRC and the output valid; registers
// return to 0xAA, 0x55, 0x01, 5000.
// Receiver stall: a waiting result does not block input; bytes keep flowing
// until a second good frame closes while the first result is still held,
// then s_tready drops until m_tready takes the held result.
module pwm_packet_deframer_crc8 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pdc_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pdc_pkg::OUT_DATA_W-1:0]  m_tdata    // pwm_0 [15:0] .. pwm_5 [95:80]
);

	pdc_pkg::cfg_t       cfg;
	pdc_pkg::parse_res_t res;
	logic                out_busy;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.out_busy (out_busy),
		.res      (res)
	);

	pdc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.pwm_limit (cfg.pwm_limit),
		.out_busy  (out_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== rtl/core/pdc_checker.sv =====
module pdc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pdc_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// input back-pressure only comes from a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// nothing is offered during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind pwm_packet_deframer_crc8 pdc_checker u_pdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
